/* src/ctbi_pkg.sv */
package ctbi_pkg;

    localparam int TEMP_FLOOR = 16384;
    localparam int STEPS_PER_UNIT = 20;
    localparam int FRAC_BITS = 12;
    localparam int NUM_BREAKS = 8;
    localparam int DIV_BITS = 56;

    localparam logic [15:0] BREAK_RESET [NUM_BREAKS] = '{
        16'(-13719), 16'(-9623), 16'(-7575), 16'(-6551),
        16'(-5527), 16'(-4503), 16'(-3479), 16'(-2455)
    };

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] num;
        logic [31:0]         den;
    } div_req_t;

endpackage

/* src/ctbi_div.sv */
module ctbi_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ctbi_pkg::div_req_t                   req,
    output logic                                 done,
    output logic signed [ctbi_pkg::DIV_BITS-1:0] quot
);

    localparam int NW = ctbi_pkg::DIV_BITS;

    logic          busy_reg;
    logic [5:0]    cnt_reg;
    logic          neg_reg;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] q_reg;
    logic [NW:0]   rem_reg;
    logic [31:0]   d_reg;
    logic          done_reg;
    logic [NW:0]   trial;
    logic [NW:0]   shifted;
    logic [NW-1:0] abs_num;
    logic [NW-1:0] qf;

    assign abs_num = req.num[NW-1] ? (~req.num + NW'(1)) : req.num;
    assign shifted = {rem_reg[NW-1:0], n_reg[NW-1]};
    assign trial = shifted - (NW + 1)'(d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && (cnt_reg == 6'd1);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            n_reg <= abs_num;
            neg_reg <= req.num[NW-1];
            d_reg <= req.den;
            rem_reg <= '0;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[NW-2:0], 1'b0};
            if (!trial[NW])
            begin
                rem_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    // floor division: negative with remainder rounds down
    assign qf = (neg_reg && rem_reg != '0) ? (q_reg + NW'(1)) : q_reg;
    assign quot = neg_reg ? $signed(~qf + NW'(1)) : $signed(qf);
    assign done = done_reg;

endmodule

/* src/cooling_table_bilinear_interp_top.sv */
// a query skips the divider when the breakpoint spacing is not positive
// otherwise a query runs the breakpoint scan and then the 56-step divider
// loads back to back; the next transaction in the cycle after a query result is issued
// a finished query waits in its last state while an earlier result is held by out_ready
// reset: breakpoints return to defaults, table contents undefined until loaded
module cooling_table_bilinear_interp_top #(
    parameter int NUM_ROWS = 8,
    parameter int NUM_COLS = 91
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [2:0]  row_sel,
    input  logic [6:0]  col_sel,
    input  logic signed [15:0] entry_value,
    input  logic [15:0] log_temp,
    input  logic signed [15:0] log_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] log_rate,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = NUM_ROWS * NUM_COLS;
    localparam int AW = $clog2(DEPTH);
    localparam int RW = $clog2(NUM_ROWS);
    localparam int CW = $clog2(NUM_COLS);
    localparam int NW = ctbi_pkg::DIV_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_RD0   = 4'd2;
    localparam logic [3:0] S_RD1   = 4'd3;
    localparam logic [3:0] S_RD2   = 4'd4;
    localparam logic [3:0] S_RD3   = 4'd5;
    localparam logic [3:0] S_RA    = 4'd6;
    localparam logic [3:0] S_RB    = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_WAIT  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [15:0] brk_reg [ctbi_pkg::NUM_BREAKS];
    logic signed [15:0] mem [DEPTH];
    logic signed [15:0] rd_reg;

    logic [3:0] state_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [19:0] frac_reg;
    logic signed [16:0] z_reg;
    logic signed [15:0] e0_reg;
    logic signed [15:0] e1_reg;
    logic signed [15:0] e2_reg;
    logic signed [37:0] ra_reg;
    logic signed [37:0] rb_reg;
    logic signed [17:0] den_reg;
    logic signed [17:0] dz_reg;
    logic signed [NW-1:0] p1_reg;
    logic signed [NW-1:0] p2_reg;
    logic signed [15:0] res_reg;
    logic signed [15:0] out_reg;
    logic out_valid_reg;

    logic [AW-1:0] rd_addr;
    logic cfg_wr;
    logic in_fire;
    logic out_push;
    logic [16:0] tclamp;
    logic [21:0] d20;
    logic [CW-1:0] col_raw;
    logic [19:0] frac_raw;
    logic signed [16:0] zc;
    logic signed [15:0] bnext;
    logic signed [37:0] row_rate;
    logic signed [15:0] eb;
    ctbi_pkg::div_req_t dreq;
    logic ddone;
    logic signed [NW-1:0] dq;
    logic signed [39:0] ra_rnd;
    logic signed [15:0] sat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = {{16{brk_reg[paddr[4:2]][15]}}, brk_reg[paddr[4:2]]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ctbi_pkg::NUM_BREAKS; k++)
            begin
                brk_reg[k] <= ctbi_pkg::BREAK_RESET[k];
            end
        end
        else if (cfg_wr && paddr[1:0] == 2'd0)
        begin
            brk_reg[paddr[4:2]] <= pwdata[15:0];
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire = in_valid && in_ready;
    assign out_push = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // temperature column and weight
    assign tclamp = (log_temp < 16'(ctbi_pkg::TEMP_FLOOR)) ? 17'd0
                  : ({1'b0, log_temp} - 17'(ctbi_pkg::TEMP_FLOOR));
    assign d20 = {tclamp, 4'd0} + {2'd0, tclamp, 2'd0} + 22'd0;
    assign col_raw = (d20[21:12] > 10'(NUM_COLS - 2)) ? CW'(NUM_COLS - 2)
                   : CW'(d20[21:12]);
    assign frac_raw = 20'(d20 - ({10'd0, 12'd0} | (22'(col_raw) << 12)));

    // metallicity clamp
    always_comb
    begin
        zc = 17'(log_z);
        if ($signed(zc) < $signed(17'($signed(brk_reg[0]))))
        begin
            zc = 17'($signed(brk_reg[0]));
        end
        if ($signed(zc) > $signed(17'($signed(brk_reg[NUM_ROWS - 1]))))
        begin
            zc = 17'($signed(brk_reg[NUM_ROWS - 1]));
        end
    end

    assign bnext = $signed(brk_reg[3'(row_reg) + 3'd1]);
    assign eb = rd_reg;
    assign row_rate = (38'(e0_reg) <<< 12)
                    + (38'(e1_reg) - 38'(e0_reg)) * $signed({18'd0, frac_reg});

    always_comb
    begin
        unique case (state_reg)
            S_RD0:   rd_addr = AW'(row_reg * NUM_COLS + col_reg);
            S_RD1:   rd_addr = AW'(row_reg * NUM_COLS + col_reg + 1);
            S_RD2:   rd_addr = AW'((row_reg + 1) * NUM_COLS + col_reg);
            S_RD3:   rd_addr = AW'((row_reg + 1) * NUM_COLS + col_reg + 1);
            default: rd_addr = AW'(row_sel * NUM_COLS + col_sel);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && req_type == ctbi_pkg::REQ_LOAD
            && 32'(row_sel) < NUM_ROWS && 32'(col_sel) < NUM_COLS)
        begin
            mem[rd_addr] <= entry_value;
        end
        rd_reg <= mem[rd_addr];
    end

    // rounding bias of half a divisor added to the doubled numerator
    assign dreq.start = (state_reg == S_DIV);
    assign dreq.num = ((p1_reg + p2_reg) <<< 1) + (NW'(den_reg) <<< 12);
    assign dreq.den = 32'({den_reg, 13'd0});

    ctbi_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .done (ddone),
        .quot (dq)
    );

    assign ra_rnd = ((40'(ra_reg) <<< 1) + 40'sd4096) >>> 13;

    always_comb
    begin
        if (dq > NW'(32767))
        begin
            sat = 16'sd32767;
        end
        else if (dq < NW'(-32768))
        begin
            sat = -16'sd32768;
        end
        else
        begin
            sat = 16'(dq);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && req_type == ctbi_pkg::REQ_QUERY)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (32'(row_reg) < NUM_ROWS - 2 && z_reg > 17'(bnext))
                    begin
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_RD0;
                    end
                end
                S_RD0:  state_reg <= S_RD1;
                S_RD1:  state_reg <= S_RD2;
                S_RD2:  state_reg <= S_RD3;
                S_RD3:  state_reg <= S_RA;
                S_RA:   state_reg <= S_RB;
                S_RB:   state_reg <= S_MUL;
                S_MUL:
                begin
                    if (den_reg <= 18'sd0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:  state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (ddone)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_push)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                row_reg <= '0;
                col_reg <= col_raw;
                frac_reg <= frac_raw;
                z_reg <= zc;
            end
            S_SCAN:
            begin
                if (32'(row_reg) < NUM_ROWS - 2 && z_reg > 17'(bnext))
                begin
                    row_reg <= row_reg + RW'(1);
                end
                den_reg <= 18'(bnext) - 18'($signed(brk_reg[3'(row_reg)]));
                dz_reg <= 18'(z_reg) - 18'($signed(brk_reg[3'(row_reg)]));
            end
            S_RD0: ;
            S_RD1: e0_reg <= eb;
            S_RD2: e1_reg <= eb;
            S_RD3: e2_reg <= eb;
            S_RA:
            begin
                ra_reg <= row_rate;
                e0_reg <= e2_reg;
                e1_reg <= eb;
            end
            S_RB: rb_reg <= row_rate;
            S_MUL:
            begin
                p1_reg <= NW'(ra_reg) * NW'(den_reg);
                p2_reg <= (NW'(rb_reg) - NW'(ra_reg)) * NW'(dz_reg);
                res_reg <= (ra_rnd > 40'sd32767) ? 16'sd32767
                         : (ra_rnd < -40'sd32768) ? -16'sd32768 : 16'(ra_rnd);
            end
            S_WAIT:
            begin
                if (ddone)
                begin
                    res_reg <= sat;
                end
            end
            S_OUT:
            begin
                if (out_push)
                begin
                    out_reg <= res_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign log_rate = out_reg;

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(log_rate))
        else $error("result dropped");
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD0 |-> 32'(row_reg) <= NUM_ROWS - 2)
        else $error("row bracket out of range");

endmodule
